// ----- src/rps_pkg.sv -----
// Package for the reversible priced stack: request and result types,
// operation codes and the control word sent to the cell chain.
// No dependencies.
package rps_pkg;

    localparam int DEF_STACK_DEPTH = 64;
    localparam int DEF_PRICE_BITS  = 16;

    localparam int TAG_W       = 8;
    localparam int COST_W      = 16;
    localparam int OP_W        = 2;
    localparam int DEPTH_OUT_W = 7;
    localparam int TOTAL_W     = 22;

    // cell index field wide enough for the largest supported depth
    localparam int MAX_IDX_W = 12;

    localparam logic [OP_W-1:0] OP_PUSH    = 2'd0;
    localparam logic [OP_W-1:0] OP_POP     = 2'd1;
    localparam logic [OP_W-1:0] OP_REVERSE = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [TAG_W-1:0]  tag;
        logic [COST_W-1:0] cost;
    } t_in_req;

    typedef struct packed {
        logic [TAG_W-1:0]       top_tag;
        logic [DEPTH_OUT_W-1:0] depth_used;
        logic [TOTAL_W-1:0]     price_total;
        logic                   is_empty;
        logic                   fault;
    } t_out_res;

    typedef enum logic [1:0] {
        CM_HOLD,
        CM_SHIFT_IN,
        CM_SHIFT_OUT,
        CM_LOAD
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode             mode;
        logic [MAX_IDX_W-1:0]   wr_idx;
        logic [MAX_IDX_W-1:0]   rd_idx;
    } t_cell_ctl;

endpackage

// ----- src/rps_cell.sv -----
// One storage cell of the stack chain: holds one entry (tag and price)
// and takes data from a neighbor or the push request. Uses rps_pkg.
module rps_cell import rps_pkg::*; #(
    parameter int ENTRY_W  = TAG_W + DEF_PRICE_BITS,
    parameter int CELL_IDX = 0
) (
    input  logic               i_clk,
    input  t_cell_ctl          i_ctl,
    input  logic [ENTRY_W-1:0] i_push_entry,
    input  logic [ENTRY_W-1:0] i_from_lower,
    input  logic [ENTRY_W-1:0] i_from_upper,
    output logic [ENTRY_W-1:0] o_entry,
    output logic [ENTRY_W-1:0] o_rd_entry
);

    localparam logic [MAX_IDX_W-1:0] MY_IDX = MAX_IDX_W'(CELL_IDX);

    logic [ENTRY_W-1:0] r_entry;

    always_ff @(posedge i_clk) begin
        case (i_ctl.mode)
            CM_SHIFT_IN: begin
                r_entry <= i_from_lower;
            end
            CM_SHIFT_OUT: begin
                r_entry <= i_from_upper;
            end
            CM_LOAD: begin
                if (i_ctl.wr_idx == MY_IDX) begin
                    r_entry <= i_push_entry;
                end
            end
            default: begin
                r_entry <= r_entry;
            end
        endcase
    end

    assign o_entry    = r_entry;
    assign o_rd_entry = (i_ctl.rd_idx == MY_IDX) ? r_entry : '0;

endmodule

// ----- src/rps_chain.sv -----
// Row of stack cells with neighbor links and the read-select reduction.
// Uses rps_pkg and rps_cell.
module rps_chain import rps_pkg::*; #(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int ENTRY_W     = TAG_W + DEF_PRICE_BITS
) (
    input  logic               i_clk,
    input  t_cell_ctl          i_ctl,
    input  logic [ENTRY_W-1:0] i_push_entry,
    output logic [ENTRY_W-1:0] o_rd_entry
);

    logic [ENTRY_W-1:0] w_entry [STACK_DEPTH];
    logic [ENTRY_W-1:0] w_rd    [STACK_DEPTH];

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic [ENTRY_W-1:0] w_lower;
        logic [ENTRY_W-1:0] w_upper;

        // the cell at the open end of the row takes the new request
        if (g == 0) begin : g_first
            assign w_lower = i_push_entry;
        end else begin : g_mid
            assign w_lower = w_entry[g-1];
        end

        if (g == STACK_DEPTH - 1) begin : g_last
            assign w_upper = w_entry[g];
        end else begin : g_inner
            assign w_upper = w_entry[g+1];
        end

        rps_cell #(
            .ENTRY_W  (ENTRY_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (i_ctl),
            .i_push_entry (i_push_entry),
            .i_from_lower (w_lower),
            .i_from_upper (w_upper),
            .o_entry      (w_entry[g]),
            .o_rd_entry   (w_rd[g])
        );
    end

    // at most one cell matches the read index; merge by OR
    always_comb begin
        o_rd_entry = '0;
        for (int k = 0; k < STACK_DEPTH; k++) begin
            o_rd_entry = o_rd_entry | w_rd[k];
        end
    end

endmodule

// ----- src/reversible_priced_stack_unit.sv -----
// Top level of the reversible priced stack: sequencer, count, direction
// flag and running price total around the cell chain. Uses rps_pkg, rps_chain.
//
//   channel   valid        stall        payload
//   -------   ----------   ----------   -----------------------
//   request   i_in_valid   o_in_stall   i_in_data  (t_in_req)
//   result    o_out_valid  i_out_stall  o_out_data (t_out_res)
//
// Each request passes three steps from acceptance to its result register: read
// the old top entry, update the cell chain, then read the new top into the result.
// The sequencer runs one request at a time, so a new request is taken only once
// the previous one has written its result and the sequencer is idle again.
// A new request is accepted while the previous result still waits to be taken.
// Reset clears state, count, direction flag, total, fault and the result valid; cells need no reset.
// A stalled result holds the sequencer in its last step until the slot frees.
module reversible_priced_stack_unit import rps_pkg::*; #(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int PRICE_BITS  = DEF_PRICE_BITS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_res o_out_data
);

    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int ENTRY_W = TAG_W + PRICE_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WRITE,
        S_PEEK
    } t_state;

    t_state                 r_state, n_state;
    logic [OP_W-1:0]        r_op;
    logic [TAG_W-1:0]       r_tag;
    logic [PRICE_BITS-1:0]  r_price;
    logic [PRICE_BITS-1:0]  r_old_price, n_old_price;
    logic [CNT_W-1:0]       r_count, n_count;
    logic                   r_flipped, n_flipped;
    logic [TOTAL_W-1:0]     r_total, n_total;
    logic                   r_fault, n_fault;
    logic                   r_out_valid, n_out_valid;
    t_out_res               r_out, n_out;

    logic                   w_accept;
    logic [31:0]            w_cost32;
    logic [31:0]            w_price32;
    logic [31:0]            w_old32;
    logic [31:0]            w_cnt32;
    logic [PRICE_BITS-1:0]  w_in_price;
    logic [ENTRY_W-1:0]     w_rd_entry;
    t_cell_ctl              w_ctl;
    logic                   w_full;
    logic                   w_empty;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_cost32   = 32'(i_in_data.cost);
    assign w_in_price = w_cost32[PRICE_BITS-1:0];
    assign w_price32  = 32'(r_price);
    assign w_old32    = 32'(r_old_price);
    assign w_cnt32    = 32'(r_count);
    assign w_full     = (r_count >= CNT_W'(STACK_DEPTH));
    assign w_empty    = (r_count == '0);

    rps_chain #(
        .STACK_DEPTH (STACK_DEPTH),
        .ENTRY_W     (ENTRY_W)
    ) u_chain (
        .i_clk        (i_clk),
        .i_ctl        (w_ctl),
        .i_push_entry ({r_tag, r_price}),
        .o_rd_entry   (w_rd_entry)
    );

    always_comb begin
        n_state     = r_state;
        n_old_price = r_old_price;
        n_count     = r_count;
        n_flipped   = r_flipped;
        n_total     = r_total;
        n_fault     = r_fault;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        w_ctl.mode   = CM_HOLD;
        w_ctl.wr_idx = MAX_IDX_W'(r_count);
        // top sits in cell 0 normally, at the far end of the arc when flipped
        w_ctl.rd_idx = r_flipped ? MAX_IDX_W'(r_count - 1'b1) : '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_old_price = w_rd_entry[PRICE_BITS-1:0];
                n_state     = S_WRITE;
            end
            S_WRITE: begin
                n_fault = 1'b0;
                case (r_op)
                    OP_PUSH: begin
                        if (w_full) begin
                            n_fault = 1'b1;
                        end else begin
                            w_ctl.mode = r_flipped ? CM_LOAD : CM_SHIFT_IN;
                            n_count    = r_count + 1'b1;
                            n_total    = r_total + w_price32[TOTAL_W-1:0];
                        end
                    end
                    OP_POP: begin
                        if (w_empty) begin
                            n_fault = 1'b1;
                        end else begin
                            w_ctl.mode = r_flipped ? CM_HOLD : CM_SHIFT_OUT;
                            n_count    = r_count - 1'b1;
                            n_total    = r_total - w_old32[TOTAL_W-1:0];
                        end
                    end
                    OP_REVERSE: begin
                        n_flipped = !r_flipped;
                    end
                    default: begin
                        n_fault = 1'b0;
                    end
                endcase
                n_state = S_PEEK;
            end
            S_PEEK: begin
                // hold until the result slot is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out.top_tag     = w_empty ? '0 : w_rd_entry[ENTRY_W-1 -: TAG_W];
                    n_out.depth_used  = w_cnt32[DEPTH_OUT_W-1:0];
                    n_out.price_total = r_total;
                    n_out.is_empty    = w_empty;
                    n_out.fault       = r_fault;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_flipped   <= 1'b0;
            r_total     <= '0;
            r_fault     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_flipped   <= n_flipped;
            r_total     <= n_total;
            r_fault     <= n_fault;
            r_out_valid <= n_out_valid;
        end
        r_old_price <= n_old_price;
        r_out       <= n_out;
        if (w_accept) begin
            r_op    <= i_in_data.op;
            r_tag   <= i_in_data.tag;
            r_price <= w_in_price;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("entry count above stack depth");

    a_empty_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_total == '0))
        else $error("empty stack with nonzero price total");

    a_read_then_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_state == S_WRITE))
        else $error("sequencer skipped the update step");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_PEEK))
        else $error("result raised outside the peek step");

    a_result_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.is_empty) |-> (o_out_data.price_total == '0))
        else $error("empty result with nonzero total");

endmodule
